/* rtl/lrcf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrcf_pkg
// Shared types and constants of the LED ring clock face.
// ----------------------------------------------------------------------------
package lrcf_pkg;

  // fixed field widths
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int CNT_W  = 7;   // led_count register and effective count
  localparam int HM_W   = 10;  // (hour mod 12) * 60 + minute
  localparam int S60_W  = 13;  // minute/second scaled by count
  localparam int S720_W = 17;  // hour-minute scaled by count
  localparam int SPC_W  = 5;   // mark spacing, at most 127 / 4

  localparam int MinCount = 4;
  localparam int MaxCount = 127;

  localparam int StepsPerRev   = 60;
  localparam int HoursPerFace  = 12;
  localparam int StepsHalfDay  = 720;

  // n / 12 == (n * 43) >> 9 for every 7-bit n
  localparam int Div12Mul   = 43;
  localparam int Div12Shift = 9;
  localparam int Div12Q_W   = 4;
  localparam int QuarterShift = 2;

  typedef enum logic [2:0] {
    REG_LED_COUNT   = 3'd0,
    REG_SHOW_SEC    = 3'd1,
    REG_SHOW_MARKS  = 3'd2,
    REG_HOUR_COLOR  = 3'd3,
    REG_MIN_COLOR   = 3'd4,
    REG_SEC_COLOR   = 3'd5,
    REG_MARK_COLOR  = 3'd6,
    REG_BG_COLOR    = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic load;   // capture the time of day
    logic setup;  // scale hands, derive spacing, clear the LED walk
    logic step;   // produce one LED
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a new LED
    logic last;      // current LED is the final one of the frame
  } sts_t;

endpackage

/* rtl/lrcf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrcf_ctrl
// Frame sequencer: accept a time, run a setup state, then walk the LEDs.
// ----------------------------------------------------------------------------
module lrcf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lrcf_pkg::sts_t sts_i,
  output lrcf_pkg::cmd_t cmd_o
);
  import lrcf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.out_free && sts_i.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
      end
      ST_RUN: begin
        cmd_o.step = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/lrcf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrcf_dp
// Hand scaling, LED walk, hand/mark selection and the output register.
// ----------------------------------------------------------------------------
module lrcf_dp #(
  parameter int IDX_W      = 6,
  parameter int COLOR_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lrcf_pkg::cmd_t              cmd_i,
  output lrcf_pkg::sts_t              sts_o,
  input  logic [lrcf_pkg::HOUR_W-1:0] hour_i,
  input  logic [lrcf_pkg::MIN_W-1:0]  minute_i,
  input  logic [lrcf_pkg::SEC_W-1:0]  second_i,
  input  logic [lrcf_pkg::CNT_W-1:0]  count_i,
  input  logic                        show_sec_i,
  input  logic                        show_marks_i,
  input  logic [COLOR_BITS-1:0]       hour_color_i,
  input  logic [COLOR_BITS-1:0]       minute_color_i,
  input  logic [COLOR_BITS-1:0]       second_color_i,
  input  logic [COLOR_BITS-1:0]       mark_color_i,
  input  logic [COLOR_BITS-1:0]       bg_color_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [IDX_W-1:0]            led_index_o,
  output logic [COLOR_BITS-1:0]       color_o,
  output logic                        last_led_o
);
  import lrcf_pkg::*;

  // captured time
  logic [HOUR_W-1:0] hour_q;
  logic [MIN_W-1:0]  min_q;
  logic [SEC_W-1:0]  sec_q;

  // per-frame setup
  logic [S60_W-1:0]  sec_pos_q, min_pos_q;
  logic [S720_W-1:0] hour_pos_q;
  logic [SPC_W-1:0]  spacing_q;
  logic              secs_en_q;

  // LED walk
  logic [CNT_W-1:0]  idx_q;
  logic [S60_W-1:0]  acc60_q;
  logic [S720_W-1:0] acc720_q;
  logic [SPC_W-1:0]  mark_cnt_q;
  logic              flag_q, flag_d;

  // output register
  logic                  out_valid_q;
  logic [IDX_W-1:0]      led_index_q;
  logic [COLOR_BITS-1:0] color_q, color_d;
  logic                  last_q;

  // setup arithmetic
  logic [HOUR_W-1:0]   hour12;
  logic [HM_W-1:0]     hm;
  logic [CNT_W+6-1:0]  div12_prod;
  logic [Div12Q_W-1:0] q12;
  logic [CNT_W-1:0]    r12;
  logic [SPC_W-1:0]    spacing_d;

  always_comb begin
    if (hour_q >= HOUR_W'(2 * HoursPerFace)) begin
      hour12 = hour_q - HOUR_W'(2 * HoursPerFace);
    end else if (hour_q >= HOUR_W'(HoursPerFace)) begin
      hour12 = hour_q - HOUR_W'(HoursPerFace);
    end else begin
      hour12 = hour_q;
    end
    hm         = HM_W'(hour12) * HM_W'(StepsPerRev) + HM_W'(min_q);
    div12_prod = (CNT_W+6)'(count_i) * (CNT_W+6)'(Div12Mul);
    q12        = Div12Q_W'(div12_prod >> Div12Shift);
    r12        = count_i - CNT_W'(q12) * CNT_W'(HoursPerFace);
    if (r12 != '0) begin
      spacing_d = SPC_W'(count_i >> QuarterShift);
    end else begin
      spacing_d = SPC_W'(q12);
    end
  end

  // hand hits: idx * D <= pos < (idx + 1) * D
  logic [S60_W:0]  acc60_nx;
  logic [S720_W:0] acc720_nx;
  logic            hit_h, hit_m, hit_s, is_last;

  assign acc60_nx  = {1'b0, acc60_q} + (S60_W+1)'(StepsPerRev);
  assign acc720_nx = {1'b0, acc720_q} + (S720_W+1)'(StepsHalfDay);
  assign hit_h = (acc720_q <= hour_pos_q) && ({1'b0, hour_pos_q} < acc720_nx);
  assign hit_m = (acc60_q <= min_pos_q) && ({1'b0, min_pos_q} < acc60_nx);
  assign hit_s = (acc60_q <= sec_pos_q) && ({1'b0, sec_pos_q} < acc60_nx);
  assign is_last = (idx_q == count_i - CNT_W'(1));

  always_comb begin
    flag_d = flag_q;
    if (!flag_q && hit_h) begin
      if (hit_m) flag_d = 1'b1;
      color_d = hour_color_i;
    end else begin
      if (hit_h) flag_d = 1'b0;
      priority if (hit_m) begin
        color_d = minute_color_i;
      end else if (secs_en_q && hit_s) begin
        color_d = second_color_i;
      end else if (show_marks_i && mark_cnt_q == '0) begin
        color_d = mark_color_i;
      end else begin
        color_d = bg_color_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hour_q <= hour_i;
      min_q  <= minute_i;
      sec_q  <= second_i;
    end
    if (cmd_i.setup) begin
      sec_pos_q  <= S60_W'(sec_q) * S60_W'(count_i);
      min_pos_q  <= S60_W'(min_q) * S60_W'(count_i);
      hour_pos_q <= S720_W'(hm) * S720_W'(count_i);
      spacing_q  <= spacing_d;
      secs_en_q  <= show_sec_i &&
                    (count_i == CNT_W'(StepsPerRev) || count_i == CNT_W'(2 * StepsPerRev));
      idx_q      <= '0;
      acc60_q    <= '0;
      acc720_q   <= '0;
      mark_cnt_q <= '0;
    end else if (cmd_i.step) begin
      idx_q      <= idx_q + CNT_W'(1);
      acc60_q    <= S60_W'(acc60_nx);
      acc720_q   <= S720_W'(acc720_nx);
      mark_cnt_q <= (mark_cnt_q == spacing_q - SPC_W'(1)) ? '0 : mark_cnt_q + SPC_W'(1);
      led_index_q <= IDX_W'(idx_q);
      color_q     <= color_d;
      last_q      <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        flag_q      <= flag_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.last     = is_last;

  assign out_valid_o = out_valid_q;
  assign led_index_o = led_index_q;
  assign color_o     = color_q;
  assign last_led_o  = last_q;

endmodule

/* rtl/led_ring_clock_face_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_ring_clock_face_top
// Renders a time of day onto an LED ring as one color per LED.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one time of day: hour,
//   minute, second. Each transfer produces one frame: n output transfers
//   (out_valid_o/out_ready_i), LED 0 .. n-1 in order, last_led_o set on the
//   final one. n is led_count clamped to 4 .. min(MAX_LEDS, 127).
//   The time is captured first, then a setup state scales the hand
//   positions and derives the hour mark spacing, and the LED walk starts.
//   After that one LED per cycle while the receiver takes them; the next
//   time is taken as soon as the final LED sits in the output register.
//   A stalled receiver holds the output register and freezes the LED walk.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i;
//   write only between frames.
//   Reset loads the default register values, clears the output valid bit
//   and the hour/minute alternation flag.
// ----------------------------------------------------------------------------
module led_ring_clock_face_top #(
  parameter int MAX_LEDS   = 64,
  parameter int COLOR_BITS = 24,
  localparam int IDX_W     = $clog2(MAX_LEDS),
  localparam int CFG_W     = (COLOR_BITS > lrcf_pkg::CNT_W) ? COLOR_BITS : lrcf_pkg::CNT_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  // time input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lrcf_pkg::HOUR_W-1:0] hour_i,
  input  logic [lrcf_pkg::MIN_W-1:0]  minute_i,
  input  logic [lrcf_pkg::SEC_W-1:0]  second_i,
  // LED output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [IDX_W-1:0]            led_index_o,
  output logic [COLOR_BITS-1:0]       color_o,
  output logic                        last_led_o
);
  import lrcf_pkg::*;

  localparam int MaxEff  = (MAX_LEDS < MaxCount) ? MAX_LEDS : MaxCount;
  localparam int ColKeep = (COLOR_BITS < 24) ? COLOR_BITS : 24;

  // register bank
  logic [CNT_W-1:0]      led_count_q;
  logic                  show_sec_q, show_marks_q;
  logic [COLOR_BITS-1:0] hour_color_q, min_color_q, sec_color_q, mark_color_q, bg_color_q;
  logic [COLOR_BITS-1:0] color_wr;
  cfg_reg_e              cfg_reg;

  // colors keep only the low min(COLOR_BITS, 24) bits of a write
  assign color_wr = COLOR_BITS'(cfg_wdata_i[ColKeep-1:0]);
  assign cfg_reg  = cfg_reg_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q  <= CNT_W'(60);
      show_sec_q   <= 1'b1;
      show_marks_q <= 1'b1;
      hour_color_q <= COLOR_BITS'(24'hFF0000);
      min_color_q  <= COLOR_BITS'(24'h00FF00);
      sec_color_q  <= COLOR_BITS'(24'h0000FF);
      mark_color_q <= COLOR_BITS'(24'h404040);
      bg_color_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg)
        REG_LED_COUNT:  led_count_q  <= cfg_wdata_i[CNT_W-1:0];
        REG_SHOW_SEC:   show_sec_q   <= cfg_wdata_i[0];
        REG_SHOW_MARKS: show_marks_q <= cfg_wdata_i[0];
        REG_HOUR_COLOR: hour_color_q <= color_wr;
        REG_MIN_COLOR:  min_color_q  <= color_wr;
        REG_SEC_COLOR:  sec_color_q  <= color_wr;
        REG_MARK_COLOR: mark_color_q <= color_wr;
        REG_BG_COLOR:   bg_color_q   <= color_wr;
        default: ;
      endcase
    end
  end

  // effective LED count; the stored register keeps its written bits
  logic [CNT_W-1:0] count;
  always_comb begin
    if (led_count_q < CNT_W'(MinCount)) begin
      count = CNT_W'(MinCount);
    end else if (led_count_q > CNT_W'(MaxEff)) begin
      count = CNT_W'(MaxEff);
    end else begin
      count = led_count_q;
    end
  end

  cmd_t cmd;
  sts_t sts;

  lrcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrcf_dp #(
    .IDX_W      (IDX_W),
    .COLOR_BITS (COLOR_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .hour_i         (hour_i),
    .minute_i       (minute_i),
    .second_i       (second_i),
    .count_i        (count),
    .show_sec_i     (show_sec_q),
    .show_marks_i   (show_marks_q),
    .hour_color_i   (hour_color_q),
    .minute_color_i (min_color_q),
    .second_color_i (sec_color_q),
    .mark_color_i   (mark_color_q),
    .bg_color_i     (bg_color_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .led_index_o    (led_index_o),
    .color_o        (color_o),
    .last_led_o     (last_led_o)
  );

endmodule
